### src/pdla_pkg.sv
// Package for the pass dependency level assigner: sizes, constants, FSM state type.
package pdla_pkg;

	localparam int MAX_PASSES    = 64;
	localparam int RESOURCE_BITS = 64;

	localparam int MASK_W  = 64;
	localparam int LEVEL_W = 6;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;

	localparam int IDX_W   = $clog2(MAX_PASSES);
	localparam int CNT_W   = $clog2(MAX_PASSES + 1);
	localparam int ENTRY_W = MASK_W + LEVEL_W;

	localparam logic [MASK_W-1:0]  RES_MASK   = (RESOURCE_BITS >= MASK_W) ? {MASK_W{1'b1}} :
		((MASK_W'(1) << RESOURCE_BITS) - MASK_W'(1));
	localparam logic [CNT_W-1:0]   PASS_LIMIT = CNT_W'(MAX_PASSES);
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = {LEVEL_W{1'b1}};
	localparam logic [INDEX_W-1:0] INDEX_MAX  = {INDEX_W{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE
	} state_t;

endpackage

### src/pdla_ram.sv
// Generic single-port RAM with registered read data.
module pdla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

### src/pass_dependency_level_assigner.sv
// Top level: assigns longest-path dependency levels to a stream of passes.
//
// channel | dir | beat contents
// s_*     | in  | tdata = read_mask, write_mask; tlast = last_pass
// m_*     | out | tdata = pass_index, level, level_count; tuser = overflow; tlast = is_last
//
// After acceptance a pass scans the stored entries, drains the last read and then writes (the scan
// and drain are skipped when the store is empty or full); the next pass waits for idle.
// The stored entries are read from one RAM port, one per cycle.
// Reset clears the pass count, max level and output valid; the RAM is not cleared.
// s_tready is high only while no pass is in work; a held result stalls the store write.
module pass_dependency_level_assigner (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // [63:0] read_mask, [127:64] write_mask
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata,   // [5:0] pass_index, [11:6] level, [18:12] level_count
	output logic         m_tuser,   // [0] overflow
	output logic         m_tlast
);

	localparam int IDX_W   = pdla_pkg::IDX_W;
	localparam int CNT_W   = pdla_pkg::CNT_W;
	localparam int LEVEL_W = pdla_pkg::LEVEL_W;
	localparam int MASK_W  = pdla_pkg::MASK_W;

	pdla_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]   pass_count_q;
	logic [LEVEL_W-1:0] max_level_q;
	logic [CNT_W-1:0]   scan_q;
	logic [MASK_W-1:0]  touched_q;
	logic [MASK_W-1:0]  wr_q;
	logic               last_q;
	logic [LEVEL_W-1:0] level_q;
	logic               rd_vld_s1;

	logic                        m_tvalid_q;
	logic [pdla_pkg::INDEX_W-1:0] out_index_q;
	logic [LEVEL_W-1:0]          out_level_q;
	logic [pdla_pkg::COUNT_W-1:0] out_count_q;
	logic                        out_over_q;
	logic                        out_last_q;

	logic                         ram_we;
	logic [IDX_W-1:0]             ram_addr;
	logic [pdla_pkg::ENTRY_W-1:0] ram_rdata;

	logic                        accept;
	logic                        over;
	logic                        out_free;
	logic                        commit;
	logic                        hit;
	logic [LEVEL_W-1:0]          cand;
	logic [LEVEL_W-1:0]          new_max;
	logic [CNT_W+6:0]            pc_ext;
	logic [pdla_pkg::INDEX_W-1:0] index;

	assign over     = pass_count_q >= pdla_pkg::PASS_LIMIT;
	assign out_free = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// entry layout: level above the write mask
	assign hit  = |(ram_rdata[MASK_W-1:0] & touched_q);
	assign cand = (ram_rdata[MASK_W +: LEVEL_W] == pdla_pkg::LEVEL_MAX) ? pdla_pkg::LEVEL_MAX :
		ram_rdata[MASK_W +: LEVEL_W] + LEVEL_W'(1);

	assign new_max = (level_q > max_level_q) ? level_q : max_level_q;
	assign pc_ext  = (CNT_W + 7)'(pass_count_q);
	assign index   = (over || pc_ext > (CNT_W + 7)'(pdla_pkg::INDEX_MAX)) ? pdla_pkg::INDEX_MAX :
		pc_ext[pdla_pkg::INDEX_W-1:0];

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		ram_we   = 1'b0;
		ram_addr = scan_q[IDX_W-1:0];
		commit   = 1'b0;
		case (state_q)
			pdla_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (over || pass_count_q == '0) ? pdla_pkg::ST_WRITE : pdla_pkg::ST_SCAN;
				end
			end
			pdla_pkg::ST_SCAN: begin
				if (scan_q == pass_count_q - CNT_W'(1)) begin
					state_d = pdla_pkg::ST_DRAIN;
				end
			end
			pdla_pkg::ST_DRAIN: begin
				state_d = pdla_pkg::ST_WRITE;
			end
			pdla_pkg::ST_WRITE: begin
				ram_addr = pass_count_q[IDX_W-1:0];
				if (out_free) begin
					commit  = 1'b1;
					ram_we  = !over;
					state_d = pdla_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pdla_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdla_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q <= '0;
			max_level_q  <= '0;
			rd_vld_s1    <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == pdla_pkg::ST_SCAN);
			if (commit) begin
				m_tvalid_q <= 1'b1;
				if (last_q) begin
					pass_count_q <= '0;
					max_level_q  <= '0;
				end else if (!over) begin
					pass_count_q <= pass_count_q + CNT_W'(1);
					max_level_q  <= new_max;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			touched_q <= (s_tdata[63:0] | s_tdata[127:64]) & pdla_pkg::RES_MASK;
			wr_q      <= s_tdata[127:64] & pdla_pkg::RES_MASK;
			last_q    <= s_tlast;
			level_q   <= '0;
			scan_q    <= '0;
		end else begin
			if (state_q == pdla_pkg::ST_SCAN) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (rd_vld_s1 && hit && cand > level_q) begin
				level_q <= cand;
			end
		end
		if (commit) begin
			out_index_q <= index;
			out_level_q <= over ? '0 : level_q;
			out_count_q <= pdla_pkg::COUNT_W'(over ? max_level_q : new_max) +
				pdla_pkg::COUNT_W'(1);
			out_over_q  <= over;
			out_last_q  <= last_q;
		end
	end

	pdla_ram #(
		.WIDTH(pdla_pkg::ENTRY_W),
		.DEPTH(pdla_pkg::MAX_PASSES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({level_q, wr_q}),
		.rdata (ram_rdata)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, out_count_q, out_level_q, out_index_q};
	assign m_tuser  = out_over_q;
	assign m_tlast  = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pass_count_q <= pdla_pkg::PASS_LIMIT)
		else $error("pass count above capacity");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pdla_pkg::ST_SCAN |-> scan_q < pass_count_q)
		else $error("scan address beyond stored passes");

	a_overflow_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[11:6] == '0 && m_tdata[5:0] == pdla_pkg::INDEX_MAX)
		else $error("overflow result not level zero at saturated index");

	a_level_in_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pdla_pkg::COUNT_W'(m_tdata[11:6]) < m_tdata[18:12])
		else $error("level not below level count");

	a_store_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> m_tvalid && !m_tuser)
		else $error("store write without result");

endmodule
